/* hdl/cma_pkg.sv */
package cma_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MAX_MARGIN = 31;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int MARGIN_W = 5;
	localparam int MARGIN_CAP_INT = (MAX_MARGIN < (STORE_DEPTH - 1) / 2) ?
		MAX_MARGIN : (STORE_DEPTH - 1) / 2;
	localparam logic [MARGIN_W-1:0] MARGIN_CAP = MARGIN_W'(MARGIN_CAP_INT);
	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1);
	localparam int SUM_W = 22;
	localparam int FRAC_BITS = 8;
	localparam int NUM_W = SUM_W + FRAC_BITS;
	localparam int CNT_W = 6;
	localparam int PEND_W = 6;
	localparam int AVG_W = 24;
	localparam int RECIP_W = 32;
	localparam int PROD_W = NUM_W + RECIP_W;

	// floor((2^32 - 1) / d), entry 0 unused
	localparam logic [RECIP_W-1:0] RECIP_TABLE [64] = '{
		32'd0,
		32'hFFFF_FFFF / 32'd1,  32'hFFFF_FFFF / 32'd2,  32'hFFFF_FFFF / 32'd3,
		32'hFFFF_FFFF / 32'd4,  32'hFFFF_FFFF / 32'd5,  32'hFFFF_FFFF / 32'd6,
		32'hFFFF_FFFF / 32'd7,  32'hFFFF_FFFF / 32'd8,  32'hFFFF_FFFF / 32'd9,
		32'hFFFF_FFFF / 32'd10, 32'hFFFF_FFFF / 32'd11, 32'hFFFF_FFFF / 32'd12,
		32'hFFFF_FFFF / 32'd13, 32'hFFFF_FFFF / 32'd14, 32'hFFFF_FFFF / 32'd15,
		32'hFFFF_FFFF / 32'd16, 32'hFFFF_FFFF / 32'd17, 32'hFFFF_FFFF / 32'd18,
		32'hFFFF_FFFF / 32'd19, 32'hFFFF_FFFF / 32'd20, 32'hFFFF_FFFF / 32'd21,
		32'hFFFF_FFFF / 32'd22, 32'hFFFF_FFFF / 32'd23, 32'hFFFF_FFFF / 32'd24,
		32'hFFFF_FFFF / 32'd25, 32'hFFFF_FFFF / 32'd26, 32'hFFFF_FFFF / 32'd27,
		32'hFFFF_FFFF / 32'd28, 32'hFFFF_FFFF / 32'd29, 32'hFFFF_FFFF / 32'd30,
		32'hFFFF_FFFF / 32'd31, 32'hFFFF_FFFF / 32'd32, 32'hFFFF_FFFF / 32'd33,
		32'hFFFF_FFFF / 32'd34, 32'hFFFF_FFFF / 32'd35, 32'hFFFF_FFFF / 32'd36,
		32'hFFFF_FFFF / 32'd37, 32'hFFFF_FFFF / 32'd38, 32'hFFFF_FFFF / 32'd39,
		32'hFFFF_FFFF / 32'd40, 32'hFFFF_FFFF / 32'd41, 32'hFFFF_FFFF / 32'd42,
		32'hFFFF_FFFF / 32'd43, 32'hFFFF_FFFF / 32'd44, 32'hFFFF_FFFF / 32'd45,
		32'hFFFF_FFFF / 32'd46, 32'hFFFF_FFFF / 32'd47, 32'hFFFF_FFFF / 32'd48,
		32'hFFFF_FFFF / 32'd49, 32'hFFFF_FFFF / 32'd50, 32'hFFFF_FFFF / 32'd51,
		32'hFFFF_FFFF / 32'd52, 32'hFFFF_FFFF / 32'd53, 32'hFFFF_FFFF / 32'd54,
		32'hFFFF_FFFF / 32'd55, 32'hFFFF_FFFF / 32'd56, 32'hFFFF_FFFF / 32'd57,
		32'hFFFF_FFFF / 32'd58, 32'hFFFF_FFFF / 32'd59, 32'hFFFF_FFFF / 32'd60,
		32'hFFFF_FFFF / 32'd61, 32'hFFFF_FFFF / 32'd62, 32'hFFFF_FFFF / 32'd63
	};

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
		logic [CNT_W-1:0] count;
		logic             last;
	} div_req_t;

endpackage

/* hdl/cma_ram.sv */
module cma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/cma_divider.sv */
module cma_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cma_pkg::div_req_t         req,
	output logic                      advance,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [cma_pkg::AVG_W-1:0] m_tdata,  // average
	output logic                      m_tlast
);
	import cma_pkg::*;

	logic                v_s1, v_s2;
	logic [NUM_W-1:0]    num_s1, num_s2;
	logic [CNT_W-1:0]    cnt_s1, cnt_s2;
	logic                last_s1, last_s2;
	logic [NUM_W-1:0]    q0_s2;
	logic [PROD_W-1:0]   prod;
	logic [NUM_W+CNT_W-1:0] back;
	logic [NUM_W+CNT_W-1:0] rem;
	logic [NUM_W-1:0]    quot;
	logic                out_valid_q;
	logic [AVG_W-1:0]    avg_q;
	logic                last_q;

	assign advance = !out_valid_q || m_tready;

	// quotient estimate is exact or one low
	assign prod = PROD_W'(num_s1) * PROD_W'(RECIP_TABLE[cnt_s1]);
	assign back = (NUM_W+CNT_W)'(q0_s2) * (NUM_W+CNT_W)'(cnt_s2);
	assign rem  = (NUM_W+CNT_W)'(num_s2) - back;
	assign quot = (rem >= (NUM_W+CNT_W)'(cnt_s2)) ? q0_s2 + NUM_W'(1) : q0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1        <= req.valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			num_s1  <= req.num;
			cnt_s1  <= req.count;
			last_s1 <= req.last;
			q0_s2   <= prod[PROD_W-1:RECIP_W];
			num_s2  <= num_s1;
			cnt_s2  <= cnt_s1;
			last_s2 <= last_s1;
			avg_q   <= quot[AVG_W-1:0];
			last_q  <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = avg_q;
	assign m_tlast  = last_q;

endmodule

/* hdl/centered_moving_average.sv */
// Centered moving average with shrinking edges. Each item carries one unsigned
// 16-bit sample; tlast marks the end of a sequence. Result i is the mean of
// samples i-m .. i+m clipped to the sequence, as unsigned fixed point with 8
// fraction bits, truncated. The margin m is taken from window_margin at the
// first sample of a sequence and held until its end. Result i is requested once
// sample i+m has arrived; the last sample flushes all pending results and the
// final one carries tlast. A sample that completes no window leaves s_tready
// high; one that completes a window holds s_tready low until its result is
// requested. A flush requests one result per cycle while m_tready does not hold
// the output, since the sample memory read for the dropped sample lands just in
// time for the next subtract. The divide by the window count is a reciprocal
// multiply with one correction step in a two-stage pipeline ahead of the output
// register.
module centered_moving_average (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            window_margin_we,
	input  logic [cma_pkg::MARGIN_W-1:0]    window_margin_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [cma_pkg::SAMPLE_BITS-1:0] s_tdata,  // sample
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [cma_pkg::AVG_W-1:0]       m_tdata,  // average
	output logic                            m_tlast
);
	import cma_pkg::*;

	state_t               state_q, state_d;
	logic [MARGIN_W-1:0]  window_margin_q;
	logic [MARGIN_W-1:0]  held_margin_q;
	logic                 active_q;
	logic                 flush_q;
	logic                 sub_q;
	logic [SUM_W-1:0]     sum_q;
	logic [ADDR_W-1:0]    wptr_q;
	logic [ADDR_W-1:0]    next_q;
	logic [MARGIN_W-1:0]  left_q;
	logic [PEND_W-1:0]    pending_q;

	logic [MARGIN_W-1:0]  margin_cfg;
	logic [MARGIN_W-1:0]  margin_cur;
	logic [PEND_W-1:0]    pend_inc;
	logic                 accept;
	logic                 emit_now;
	logic                 fire;
	logic                 final_emit;
	logic                 drop_old;
	logic [SAMPLE_BITS-1:0] old_sample;
	logic [SUM_W-1:0]     sum_eff;
	logic [ADDR_W-1:0]    old_addr;
	logic                 advance;
	div_req_t             req;

	assign margin_cfg = (window_margin_q > MARGIN_CAP) ? MARGIN_CAP : window_margin_q;
	assign margin_cur = active_q ? held_margin_q : margin_cfg;
	assign pend_inc   = pending_q + PEND_W'(1);
	assign accept     = s_tvalid && s_tready;
	assign emit_now   = accept &&
		((pend_inc == PEND_W'(margin_cur) + PEND_W'(1)) || s_tlast);
	assign drop_old   = (left_q >= held_margin_q);
	assign final_emit = fire && flush_q && (pending_q == PEND_W'(1));
	assign sum_eff    = sub_q ? sum_q - SUM_W'(old_sample) : sum_q;
	assign old_addr   = next_q - ADDR_W'(held_margin_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (emit_now) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (fire && (!flush_q || pending_q == PEND_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		fire     = 1'b0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EMIT: fire = advance;
			default: begin
				s_tready = 1'b0;
				fire     = 1'b0;
			end
		endcase
	end

	always_comb begin
		req.valid = fire;
		req.num   = {sum_eff, FRAC_BITS'(0)};
		req.count = CNT_W'(left_q) + CNT_W'(pending_q);
		req.last  = final_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_margin_q <= MARGIN_RESET;
			held_margin_q   <= '0;
			active_q        <= 1'b0;
			flush_q         <= 1'b0;
			sub_q           <= 1'b0;
			sum_q           <= '0;
			wptr_q          <= '0;
			next_q          <= '0;
			left_q          <= '0;
			pending_q       <= '0;
		end else begin
			state_q <= state_d;
			if (window_margin_we) begin
				window_margin_q <= window_margin_wdata;
			end
			sum_q <= accept ? sum_eff + SUM_W'(s_tdata) : sum_eff;
			sub_q <= 1'b0;
			if (accept) begin
				held_margin_q <= margin_cur;
				active_q      <= 1'b1;
				flush_q       <= s_tlast;
				wptr_q        <= wptr_q + ADDR_W'(1);
				pending_q     <= pend_inc;
			end
			if (fire) begin
				if (final_emit) begin
					held_margin_q <= '0;
					active_q      <= 1'b0;
					flush_q       <= 1'b0;
					sum_q         <= '0;
					wptr_q        <= '0;
					next_q        <= '0;
					left_q        <= '0;
					pending_q     <= '0;
				end else begin
					next_q    <= next_q + ADDR_W'(1);
					pending_q <= pending_q - PEND_W'(1);
					if (drop_old) begin
						sub_q <= 1'b1;
					end else begin
						left_q <= left_q + MARGIN_W'(1);
					end
				end
			end
		end
	end

	cma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (wptr_q),
		.wdata (s_tdata),
		.raddr (old_addr),
		.rdata (old_sample)
	);

	cma_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PEND_W'(held_margin_q) + PEND_W'(1))
		else $error("pending count beyond window");

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= held_margin_q)
		else $error("left count beyond margin");

	a_sub_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> $past(fire))
		else $error("subtract without a preceding emit");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		final_emit |=> (pending_q == '0 && !active_q && state_q == ST_IDLE))
		else $error("sequence state not cleared after flush");

endmodule
